[rtl/core/baro_temp_pressure_compensation_assert.svh]
// Assertion macros shared by the compensation pipeline.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH

`ifndef SYNTHESIS

`define BTPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define BTPC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) else $error(msg);

`else

`define BTPC_ASSERT(label, clk, rst_n, prop, msg)

`define BTPC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)

`endif

`endif

[rtl/core/btpc_pkg.sv]
package btpc_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 48;

    localparam logic [CFG_INDEX_BITS-1:0] REG_OVERSAMPLING    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CAL_FIRST_TRIO  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CAL_SECOND_TRIO = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CAL_B_PAIR      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CAL_M_PAIR      = 3'd4;

    localparam int RAW_TEMP_BITS  = 16;
    localparam int RAW_PRESS_BITS = 19;
    localparam int TEMP_BITS      = 16;
    localparam int PRESS_BITS     = 18;

    localparam int B6_OFFSET    = 4000;
    localparam int P_SQ_GAIN    = 3038;
    localparam int P_LIN_GAIN   = -7357;
    localparam int P_OFFSET     = 3791;
    localparam int X3_OFFSET    = 32768;
    localparam int TEMP_MAX     = 32767;
    localparam int TEMP_MIN     = -32768;
    localparam int PRESS_MAX    = 262143;
    localparam logic [15:0] B7_SCALE = 16'd50000;

endpackage

[rtl/core/btpc_div.sv]
module btpc_div #(
    parameter int W  = 32,
    parameter int PW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [W-1:0]  dividend,
    input  logic [W-1:0]  divisor,
    input  logic [PW-1:0] pay_in,
    output logic          out_valid,
    output logic [W-1:0]  quotient,
    output logic [PW-1:0] pay_out
);

    // One quotient bit per stage, restoring division. The divisor must be nonzero.
    logic [W-1:0]  rem_reg [W];
    logic [W-1:0]  quo_reg [W];
    logic [W-1:0]  den_reg [W];
    logic [PW-1:0] pay_reg [W];
    logic [W-1:0]  vld_reg;

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W-1:0]  rem_in;
        logic [W-1:0]  quo_in;
        logic [W-1:0]  den_in;
        logic [PW-1:0] pay_s;
        logic          v_in;
        logic [W:0]    shifted;
        logic [W+1:0]  diff;
        logic          ge;
        logic [W-1:0]  rem_next;
        logic [W-1:0]  quo_next;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = dividend;
            assign den_in = divisor;
            assign pay_s  = pay_in;
            assign v_in   = in_valid;
        end
        else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
            assign pay_s  = pay_reg[k-1];
            assign v_in   = vld_reg[k-1];
        end

        always_comb
        begin
            shifted  = {rem_in, quo_in[W-1]};
            diff     = {1'b0, shifted} - {2'b00, den_in};
            ge       = !diff[W+1];
            rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
            quo_next = {quo_in[W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
                den_reg[k] <= den_in;
                pay_reg[k] <= pay_s;
            end
        end
    end

    assign out_valid = vld_reg[W-1];
    assign quotient  = quo_reg[W-1];
    assign pay_out   = pay_reg[W-1];

endmodule

[rtl/core/baro_temp_pressure_compensation.sv]
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    raw_temp, raw_press
// output    out        out_valid/out_ready  temp_tenths, press_pa, div_error
// config    in         cfg_we               cfg_index, cfg_data
//
// One reading pair enters per cycle while the pipeline is not held.
// Most of the pipeline depth lies in the two dividers, each resolving one quotient bit per stage.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears the valid bits and the configuration registers.
module baro_temp_pressure_compensation #(
    parameter int WORD_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [btpc_pkg::RAW_TEMP_BITS-1:0]    raw_temp,
    input  logic [btpc_pkg::RAW_PRESS_BITS-1:0]   raw_press,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [btpc_pkg::TEMP_BITS-1:0] temp_tenths,
    output logic [btpc_pkg::PRESS_BITS-1:0]       press_pa,
    output logic                                  div_error,
    input  logic                                  cfg_we,
    input  logic [btpc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [btpc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    import btpc_pkg::*;

    localparam int W = WORD_BITS;
    localparam int P1W = W + RAW_PRESS_BITS + 2;
    localparam int P2W = TEMP_BITS + 2;
    localparam logic signed [W-1:0] T_MAX = W'(TEMP_MAX);
    localparam logic signed [W-1:0] T_MIN = W'(TEMP_MIN);
    localparam logic signed [W-1:0] P_MAX = W'(PRESS_MAX);

    // Configuration registers
    logic [1:0]  oss_reg;
    logic [47:0] trio1_reg;
    logic [47:0] trio2_reg;
    logic [31:0] bpair_reg;
    logic [31:0] mpair_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oss_reg   <= '0;
            trio1_reg <= '0;
            trio2_reg <= '0;
            bpair_reg <= '0;
            mpair_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OVERSAMPLING:    oss_reg   <= cfg_data[1:0];
                REG_CAL_FIRST_TRIO:  trio1_reg <= cfg_data[47:0];
                REG_CAL_SECOND_TRIO: trio2_reg <= cfg_data[47:0];
                REG_CAL_B_PAIR:      bpair_reg <= cfg_data[31:0];
                REG_CAL_M_PAIR:      mpair_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic signed [W-1:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [W-1:0] ac4, ac5, ac6;

    assign ac1 = W'(signed'(trio1_reg[47:32]));
    assign ac2 = W'(signed'(trio1_reg[31:16]));
    assign ac3 = W'(signed'(trio1_reg[15:0]));
    assign ac4 = W'(trio2_reg[47:32]);
    assign ac5 = W'(trio2_reg[31:16]);
    assign ac6 = W'(trio2_reg[15:0]);
    assign b1  = W'(signed'(bpair_reg[31:16]));
    assign b2  = W'(signed'(bpair_reg[15:0]));
    assign mc  = W'(signed'(mpair_reg[31:16]));
    assign md  = W'(signed'(mpair_reg[15:0]));

    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // Stage A: x1 and the temperature divisor, split into magnitudes.
    logic signed [W-1:0] a_diff, a_prod, x1a_next, a_den, a_num;
    logic [W-1:0] ma_next, mb_next;
    logic va_reg;
    logic signed [W-1:0] x1a_reg;
    logic [W-1:0] ma_reg, mb_reg;
    logic [RAW_PRESS_BITS-1:0] upa_reg;
    logic nega_reg, erra_reg;

    always_comb
    begin
        a_diff   = W'(raw_temp) - ac6;
        a_prod   = a_diff * ac5;
        x1a_next = a_prod >>> 15;
        a_den    = x1a_next + md;
        a_num    = mc <<< 11;
        ma_next  = a_num[W-1] ? W'(-a_num) : a_num;
        if (a_den == '0)
            mb_next = W'(1);
        else
            mb_next = a_den[W-1] ? W'(-a_den) : a_den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (adv)
            va_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1a_reg  <= x1a_next;
            ma_reg   <= ma_next;
            mb_reg   <= mb_next;
            upa_reg  <= raw_press;
            nega_reg <= a_num[W-1] ^ a_den[W-1];
            erra_reg <= (a_den == '0);
        end
    end

    logic d1_valid;
    logic [W-1:0] d1_q;
    logic [P1W-1:0] d1_pay;

    btpc_div #(.W(W), .PW(P1W)) u_temp_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (va_reg),
        .dividend  (ma_reg),
        .divisor   (mb_reg),
        .pay_in    ({x1a_reg, upa_reg, nega_reg, erra_reg}),
        .out_valid (d1_valid),
        .quotient  (d1_q),
        .pay_out   (d1_pay)
    );

    // Stage B: b5, temperature and b6.
    logic signed [W-1:0] b_x1, b_x2, b_b5, b_t8, b_t, b6_next;
    logic [TEMP_BITS-1:0] tt_next;
    logic vb_reg, errb_reg;
    logic signed [W-1:0] b6b_reg;
    logic [TEMP_BITS-1:0] ttb_reg;
    logic [RAW_PRESS_BITS-1:0] upb_reg;

    always_comb
    begin
        b_x1    = d1_pay[P1W-1 -: W];
        b_x2    = d1_pay[1] ? W'(-d1_q) : d1_q;
        b_b5    = b_x1 + b_x2;
        b_t8    = b_b5 + W'(8);
        b_t     = b_t8 >>> 4;
        b6_next = b_b5 - W'(B6_OFFSET);
        if (b_t > T_MAX)
            tt_next = T_MAX[TEMP_BITS-1:0];
        else if (b_t < T_MIN)
            tt_next = T_MIN[TEMP_BITS-1:0];
        else
            tt_next = b_t[TEMP_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (adv)
            vb_reg <= d1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b6b_reg  <= b6_next;
            ttb_reg  <= tt_next;
            upb_reg  <= d1_pay[RAW_PRESS_BITS+1:2];
            errb_reg <= d1_pay[0];
        end
    end

    // Stage C: products of b6.
    logic signed [W-1:0] c_sq, c_p2, c_p3, sq_next, x2p_next, x1p3_next;
    logic vc_reg, errc_reg;
    logic signed [W-1:0] sqc_reg, x2pc_reg, x1p3c_reg;
    logic [TEMP_BITS-1:0] ttc_reg;
    logic [RAW_PRESS_BITS-1:0] upc_reg;

    always_comb
    begin
        c_sq      = b6b_reg * b6b_reg;
        c_p2      = ac2 * b6b_reg;
        c_p3      = ac3 * b6b_reg;
        sq_next   = c_sq >>> 12;
        x2p_next  = c_p2 >>> 11;
        x1p3_next = c_p3 >>> 13;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (adv)
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqc_reg   <= sq_next;
            x2pc_reg  <= x2p_next;
            x1p3c_reg <= x1p3_next;
            ttc_reg   <= ttb_reg;
            upc_reg   <= upb_reg;
            errc_reg  <= errb_reg;
        end
    end

    // Stage D: products of the squared term.
    logic signed [W-1:0] d_p1, d_p2, x1d_next, x2bd_next;
    logic vd_reg, errd_reg;
    logic signed [W-1:0] x1d_reg, x2bd_reg, x2pd_reg, x1p3d_reg;
    logic [TEMP_BITS-1:0] ttd_reg;
    logic [RAW_PRESS_BITS-1:0] upd_reg;

    always_comb
    begin
        d_p1      = b2 * sqc_reg;
        d_p2      = b1 * sqc_reg;
        x1d_next  = d_p1 >>> 11;
        x2bd_next = d_p2 >>> 16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= 1'b0;
        else if (adv)
            vd_reg <= vc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1d_reg   <= x1d_next;
            x2bd_reg  <= x2bd_next;
            x2pd_reg  <= x2pc_reg;
            x1p3d_reg <= x1p3c_reg;
            ttd_reg   <= ttc_reg;
            upd_reg   <= upc_reg;
            errd_reg  <= errc_reg;
        end
    end

    // Stage E: b3 and the x3 term for b4.
    logic signed [W-1:0] e_x3, e_t1, e_t2, e_t3, b3_next, e_s, x3b_next;
    logic ve_reg, erre_reg;
    logic signed [W-1:0] b3e_reg, x3be_reg;
    logic [TEMP_BITS-1:0] tte_reg;
    logic [RAW_PRESS_BITS-1:0] upe_reg;

    always_comb
    begin
        e_x3     = x1d_reg + x2pd_reg;
        e_t1     = (ac1 <<< 2) + e_x3;
        e_t2     = e_t1 << oss_reg;
        e_t3     = e_t2 + W'(2);
        b3_next  = e_t3 >>> 2;
        e_s      = x1p3d_reg + x2bd_reg + W'(2);
        x3b_next = e_s >>> 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve_reg <= 1'b0;
        else if (adv)
            ve_reg <= vd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b3e_reg  <= b3_next;
            x3be_reg <= x3b_next;
            tte_reg  <= ttd_reg;
            upe_reg  <= upd_reg;
            erre_reg <= errd_reg;
        end
    end

    // Stage F: b4 and b7, prepared for the unsigned divider.
    logic [W-1:0] f_u, f_prod, f_b4, f_b7, f_diff, f_dividend, f_divisor;
    logic [15:0] f_scale;
    logic vf_reg, errf_reg, postf_reg;
    logic [W-1:0] dvdf_reg, dvsf_reg;
    logic [TEMP_BITS-1:0] ttf_reg;

    always_comb
    begin
        f_u        = x3be_reg + W'(X3_OFFSET);
        f_prod     = ac4 * f_u;
        f_b4       = f_prod >> 15;
        f_scale    = B7_SCALE >> oss_reg;
        f_diff     = W'(upe_reg) - b3e_reg;
        f_b7       = f_diff * W'(f_scale);
        f_dividend = f_b7[W-1] ? f_b7 : (f_b7 << 1);
        f_divisor  = (f_b4 == '0) ? W'(1) : f_b4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= 1'b0;
        else if (adv)
            vf_reg <= ve_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dvdf_reg  <= f_dividend;
            dvsf_reg  <= f_divisor;
            postf_reg <= f_b7[W-1];
            errf_reg  <= erre_reg || (f_b4 == '0);
            ttf_reg   <= tte_reg;
        end
    end

    logic d2_valid;
    logic [W-1:0] d2_q;
    logic [P2W-1:0] d2_pay;

    btpc_div #(.W(W), .PW(P2W)) u_press_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (vf_reg),
        .dividend  (dvdf_reg),
        .divisor   (dvsf_reg),
        .pay_in    ({ttf_reg, errf_reg, postf_reg}),
        .out_valid (d2_valid),
        .quotient  (d2_q),
        .pay_out   (d2_pay)
    );

    // Stage G: raw pressure and its correction products.
    logic signed [W-1:0] g_p, g_x1, g_sq, g_lin, x2g_next;
    logic vg_reg, errg_reg;
    logic signed [W-1:0] pg_reg, sqg_reg, x2g_reg;
    logic [TEMP_BITS-1:0] ttg_reg;

    always_comb
    begin
        g_p      = d2_pay[0] ? (d2_q << 1) : d2_q;
        g_x1     = g_p >>> 8;
        g_sq     = g_x1 * g_x1;
        g_lin    = g_p * W'(P_LIN_GAIN);
        x2g_next = g_lin >>> 16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vg_reg <= 1'b0;
        else if (adv)
            vg_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pg_reg   <= g_p;
            sqg_reg  <= g_sq;
            x2g_reg  <= x2g_next;
            ttg_reg  <= d2_pay[P2W-1:2];
            errg_reg <= d2_pay[1];
        end
    end

    // Stage H: scaled square term.
    logic signed [W-1:0] h_prod, x1h_next;
    logic vh_reg, errh_reg;
    logic signed [W-1:0] ph_reg, x1h_reg, x2h_reg;
    logic [TEMP_BITS-1:0] tth_reg;

    always_comb
    begin
        h_prod   = sqg_reg * W'(P_SQ_GAIN);
        x1h_next = h_prod >>> 16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vh_reg <= 1'b0;
        else if (adv)
            vh_reg <= vg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ph_reg   <= pg_reg;
            x1h_reg  <= x1h_next;
            x2h_reg  <= x2g_reg;
            tth_reg  <= ttg_reg;
            errh_reg <= errg_reg;
        end
    end

    // Stage I: final pressure, saturation and the output register.
    logic signed [W-1:0] i_s, i_p;
    logic [PRESS_BITS-1:0] press_next;
    logic [TEMP_BITS-1:0] temp_next;
    logic out_valid_reg, err_out_reg;
    logic [TEMP_BITS-1:0] temp_out_reg;
    logic [PRESS_BITS-1:0] press_out_reg;

    always_comb
    begin
        i_s = x1h_reg + x2h_reg + W'(P_OFFSET);
        i_p = ph_reg + (i_s >>> 4);
        if (i_p[W-1])
            press_next = '0;
        else if (i_p > P_MAX)
            press_next = P_MAX[PRESS_BITS-1:0];
        else
            press_next = i_p[PRESS_BITS-1:0];
        temp_next = tth_reg;
        if (errh_reg)
        begin
            press_next = '0;
            temp_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vh_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            temp_out_reg  <= temp_next;
            press_out_reg <= press_next;
            err_out_reg   <= errh_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign temp_tenths = signed'(temp_out_reg);
    assign press_pa    = press_out_reg;
    assign div_error   = err_out_reg;

`include "baro_temp_pressure_compensation_assert.svh"

    `BTPC_ASSERT(a_err_zero, clk, rst_n, (out_valid && div_error) |-> (temp_tenths == '0 && press_pa == '0), "error result carries nonzero fields")
    `BTPC_ASSERT_NEXT(a_take, clk, rst_n, (in_valid && in_ready), va_reg, "accepted transaction did not enter the pipeline")
    `BTPC_ASSERT_NEXT(a_hold, clk, rst_n, (out_valid && !out_ready), (out_valid && $stable(press_pa) && $stable(temp_tenths)), "stalled result was lost")

endmodule
